[rtl/ppa_pkg.sv]
// ----------------------------------------------------------------------------
// ppa_pkg: shared types and constants for the per-cell pedestal averager
// Field widths, store layout, stream packing and action codes.
// ----------------------------------------------------------------------------
package ppa_pkg;

  localparam int unsigned BOARDS             = 4;
  localparam int unsigned CHANNELS_PER_BOARD = 8;

  localparam int unsigned BOARD_W      = 2;
  localparam int unsigned CHAN_W       = 3;
  localparam int unsigned BLOCK_W      = 9;
  localparam int unsigned SAMPLE_POS_W = 6;
  localparam int unsigned ADC_W        = 12;
  localparam int unsigned SAMPLE_BITS  = 12;
  localparam int unsigned MEAN_W       = 12;

  localparam int unsigned SUM_W      = 32;
  localparam int unsigned COUNT_BITS = 20;

  // channel = board*8 + chan and cell = block*64 + sample map onto a plain
  // concatenation, as both multipliers are powers of two and the cell ring
  // is exactly BLOCK_W + SAMPLE_POS_W bits wide
  localparam int unsigned CELL_W = BLOCK_W + SAMPLE_POS_W;
  localparam int unsigned ADDR_W = BOARD_W + CHAN_W + CELL_W;

  // divider operands: 2*sum + count, 2*count
  localparam int unsigned NUM_W  = SUM_W + 2;
  localparam int unsigned DEN_W  = COUNT_BITS + 1;
  localparam int unsigned STEP_W = $clog2(NUM_W + 1);

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  localparam logic ACT_ACCUM = 1'b0;
  localparam logic ACT_READ  = 1'b1;

  typedef logic [ADDR_W-1:0] addr_t;

  typedef struct packed {
    logic [COUNT_BITS-1:0] count;
    logic [SUM_W-1:0]      sum;
  } cell_t;

  typedef struct packed {
    logic [ADC_W-1:0]        adc_value;
    logic [SAMPLE_POS_W-1:0] sample_in_block;
    logic [BLOCK_W-1:0]      block;
    logic [CHAN_W-1:0]       channel_in_board;
    logic [BOARD_W-1:0]      board;
  } in_data_t;

  typedef struct packed {
    logic quality_pass;
    logic is_calpulser;
    logic action;
  } in_user_t;

  typedef struct packed {
    logic count_saturated;
    logic has_samples;
  } out_user_t;

endpackage

[rtl/ppa_store.sv]
// ----------------------------------------------------------------------------
// ppa_store: sum and count store, one entry per channel and cell
// Single write port, single read port with registered read data.
// ----------------------------------------------------------------------------
module ppa_store (
  input  logic          clk_i,
  input  logic          we_i,
  input  ppa_pkg::addr_t waddr_i,
  input  ppa_pkg::cell_t wdata_i,
  input  ppa_pkg::addr_t raddr_i,
  output ppa_pkg::cell_t rdata_o
);
  import ppa_pkg::*;

  localparam int unsigned DEPTH = 1 << ADDR_W;

  cell_t mem [DEPTH];
  cell_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/ppa_div.sv]
// ----------------------------------------------------------------------------
// ppa_div: bit-serial restoring divider
// One quotient bit per cycle; keeps the low MEAN_W bits of the quotient.
// ----------------------------------------------------------------------------
module ppa_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [ppa_pkg::NUM_W-1:0]   num_i,
  input  logic [ppa_pkg::DEN_W-1:0]   den_i,
  output logic                        done_o,
  output logic [ppa_pkg::MEAN_W-1:0]  quot_o
);
  import ppa_pkg::*;

  logic [NUM_W-1:0]  num_q, num_d;
  logic [DEN_W-1:0]  den_q, den_d;
  logic [DEN_W-1:0]  rem_q, rem_d;
  logic [MEAN_W-1:0] quot_q, quot_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic              busy_q, busy_d;
  logic              done_q, done_d;

  logic [DEN_W:0]    trial;
  logic [DEN_W:0]    diff;
  logic              fits;

  assign trial = {rem_q, num_q[NUM_W-1]};
  assign diff  = trial - {1'b0, den_q};
  assign fits  = (trial >= {1'b0, den_q});

  always_comb begin
    num_d  = num_q;
    den_d  = den_q;
    rem_d  = rem_q;
    quot_d = quot_q;
    step_d = step_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      num_d  = num_i;
      den_d  = den_i;
      rem_d  = '0;
      quot_d = '0;
      step_d = STEP_W'(NUM_W);
      busy_d = 1'b1;
    end else if (busy_q) begin
      num_d  = {num_q[NUM_W-2:0], 1'b0};
      // remainder stays below the divisor, so the top bit drops cleanly
      rem_d  = fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      quot_d = {quot_q[MEAN_W-2:0], fits};
      step_d = step_q - STEP_W'(1);
      if (step_q == STEP_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q  <= num_d;
    den_q  <= den_d;
    rem_q  <= rem_d;
    quot_q <= quot_d;
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

[rtl/per_cell_pedestal_averager_top.sv]
// ----------------------------------------------------------------------------
// per_cell_pedestal_averager_top: per-cell pedestal sum/count and mean readout
//
//   port group   dir   contents
//   s_axis_*     in    accumulate or read item for one channel/cell
//   m_axis_*     out   rounded mean of a cell (read items only)
//   APB          in    include_calpulsers register at address 0
//
// An accumulate item does a store read, then a saturating add and write back.
// A read of a filled cell goes through lookup, the one-bit-per-cycle divider
// (34 steps) and hand-off; a read of an empty cell skips the divider.
// After reset all 1048576 store entries are swept to zero, one per cycle; no
// item is taken meanwhile, while register writes are. A waiting result does
// not stop accumulate items; a read waits for it to be taken.
// ----------------------------------------------------------------------------
module per_cell_pedestal_averager_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  // tdata: board[1:0], channel_in_board[4:2], block[13:5],
  //        sample_in_block[19:14], adc_value[31:20]
  input  logic [31:0] s_axis_tdata,
  // tuser: action[0], is_calpulser[1], quality_pass[2]
  input  logic [2:0]  s_axis_tuser,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // tdata: mean_value[11:0], zero[15:12]
  output logic [15:0] m_axis_tdata,
  // tuser: has_samples[0], count_saturated[1]
  output logic [1:0]  m_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import ppa_pkg::*;

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_LOOK  = 3'd2;
  localparam logic [2:0] S_DIV   = 3'd3;
  localparam logic [2:0] S_OUT   = 3'd4;

  in_data_t in_data;
  in_user_t in_user;

  logic [2:0]       state_q, state_d;
  addr_t            clr_addr_q, clr_addr_d;
  logic             incl_q;

  logic             act_q;
  logic             keep_q;
  logic             ok_q;
  logic [ADC_W-1:0] adc_q;
  addr_t            addr_q;

  logic [MEAN_W-1:0] res_mean_q, res_mean_d;
  logic              res_has_q, res_has_d;
  logic              res_sat_q, res_sat_d;

  logic              out_valid_q, out_valid_d;
  logic [MEAN_W-1:0] out_mean_q;
  out_user_t         out_user_q;
  logic              out_load;

  logic   in_fire;
  logic   in_ok;
  addr_t  in_addr;

  logic   mem_we;
  addr_t  mem_waddr;
  cell_t  mem_wdata;
  cell_t  mem_rdata;

  logic [SUM_W:0]    sum_ext;
  logic [SUM_W-1:0]  sum_sat;
  logic [NUM_W-1:0]  div_num;
  logic [DEN_W-1:0]  div_den;
  logic              div_start;
  logic              div_done;
  logic [MEAN_W-1:0] div_quot;
  logic              cfg_wr;

  assign in_data = in_data_t'(s_axis_tdata);
  assign in_user = in_user_t'(s_axis_tuser);

  assign in_ok = (32'(in_data.board) < BOARDS) &&
                 (32'(in_data.channel_in_board) < CHANNELS_PER_BOARD);
  assign in_addr = {in_data.board, in_data.channel_in_board,
                    in_data.block, in_data.sample_in_block};

  assign s_axis_tready = (state_q == S_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  // configuration
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == 1'b0);
  assign prdata = (paddr[2] == 1'b0) ? {31'd0, incl_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      incl_q <= 1'b0;
    end else if (cfg_wr) begin
      incl_q <= pwdata[0];
    end
  end

  // saturating accumulate; only SAMPLE_BITS of the ADC code count
  assign sum_ext = {1'b0, mem_rdata.sum} +
                   (SUM_W + 1)'(adc_q[SAMPLE_BITS-1:0]);
  assign sum_sat = sum_ext[SUM_W] ? '1 : sum_ext[SUM_W-1:0];

  // rounded mean = floor((2*sum + count) / (2*count))
  assign div_num = {1'b0, mem_rdata.sum, 1'b0} + NUM_W'(mem_rdata.count);
  assign div_den = {mem_rdata.count, 1'b0};

  assign out_load = (state_q == S_OUT) && (!out_valid_q || m_axis_tready);

  always_comb begin
    state_d    = state_q;
    clr_addr_d = clr_addr_q;
    res_mean_d = res_mean_q;
    res_has_d  = res_has_q;
    res_sat_d  = res_sat_q;
    mem_we     = 1'b0;
    mem_waddr  = addr_q;
    mem_wdata  = '0;
    div_start  = 1'b0;
    unique case (state_q)
      S_CLEAR: begin
        mem_we     = 1'b1;
        mem_waddr  = clr_addr_q;
        clr_addr_d = clr_addr_q + ADDR_W'(1);
        if (clr_addr_q == '1) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_fire) begin
          state_d = S_LOOK;
        end
      end
      S_LOOK: begin
        if (act_q == ACT_ACCUM) begin
          if (keep_q && (mem_rdata.count != COUNT_MAX)) begin
            mem_we          = 1'b1;
            mem_wdata.sum   = sum_sat;
            mem_wdata.count = mem_rdata.count + COUNT_BITS'(1);
          end
          state_d = S_IDLE;
        end else if (ok_q && (mem_rdata.count != '0)) begin
          res_has_d = 1'b1;
          res_sat_d = (mem_rdata.count == COUNT_MAX);
          div_start = 1'b1;
          state_d   = S_DIV;
        end else begin
          res_mean_d = '0;
          res_has_d  = 1'b0;
          res_sat_d  = 1'b0;
          state_d    = S_OUT;
        end
      end
      S_DIV: begin
        if (div_done) begin
          res_mean_d = div_quot;
          state_d    = S_OUT;
        end
      end
      S_OUT: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_addr_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_addr_q  <= clr_addr_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      act_q  <= in_user.action;
      ok_q   <= in_ok;
      keep_q <= in_ok && in_user.quality_pass && (!in_user.is_calpulser || incl_q);
      adc_q  <= in_data.adc_value;
      addr_q <= in_addr;
    end
    res_mean_q <= res_mean_d;
    res_has_q  <= res_has_d;
    res_sat_q  <= res_sat_d;
    if (out_load) begin
      out_mean_q                 <= res_mean_q;
      out_user_q.has_samples     <= res_has_q;
      out_user_q.count_saturated <= res_sat_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'd0, out_mean_q};
  assign m_axis_tuser  = out_user_q;

  ppa_store u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (in_addr),
    .rdata_o (mem_rdata)
  );

  ppa_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

endmodule
